FILE: src/mpd_pkg.sv
// ============================================================================
// mpd_pkg: shared types and constants for the Morse key timing decoder
// Holds the result-burst descriptor that travels from the front part to the
// back part, the event kind codes and the configuration register indexes.
// ============================================================================
`default_nettype none

package mpd_pkg;

    // Default sizing
    localparam int MAX_SYMBOLS  = 8;
    localparam int COUNTER_BITS = 16;
    localparam int QUEUE_DEPTH  = 4;

    // Fixed field widths
    localparam int CFG_W   = 16;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 4;
    localparam int BITS_W  = 8;
    localparam int INDEX_W = 2;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_DAH_THRESHOLD   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_LETTER_GAP      = 2'd1;
    localparam logic [INDEX_W-1:0] REG_WORD_GAP        = 2'd2;
    localparam logic [INDEX_W-1:0] REG_RECEIVE_TIMEOUT = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] DAH_THRESHOLD_RST   = 16'd750;
    localparam logic [CFG_W-1:0] LETTER_GAP_RST      = 16'd750;
    localparam logic [CFG_W-1:0] WORD_GAP_RST        = 16'd1750;
    localparam logic [CFG_W-1:0] RECEIVE_TIMEOUT_RST = 16'd2500;

    // Result event kinds
    typedef enum logic [KIND_W-1:0] {
        EV_LETTER   = 2'd0,
        EV_WORD_GAP = 2'd1,
        EV_END_MSG  = 2'd2
    } event_kind_t;

    // Everything one tick produces, in beat order: letter, word gap, end
    typedef struct packed {
        logic               has_letter;
        logic               has_word;
        logic               has_end;
        logic [COUNT_W-1:0] count;
        logic [BITS_W-1:0]  bits;
        logic               too_long;
    } burst_t;

endpackage : mpd_pkg

`default_nettype wire

FILE: src/mpd_fifo.sv
// ============================================================================
// mpd_fifo: small register queue
// Holds result-burst descriptors between the front and back parts so that
// each side can stall on its own. One push and one pop per cycle.
// ============================================================================
`default_nettype none

module mpd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && not_empty;

    // Pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : mpd_fifo

`default_nettype wire

FILE: src/mpd_front.sv
// ============================================================================
// mpd_front: tick classifier
// Holds the configuration registers and the timing state. Each accepted tick
// is timed against the thresholds combinationally; the results it causes are
// packed into one descriptor and pushed into the queue.
// ============================================================================
`default_nettype none

module mpd_front #(
    parameter int MAX_SYMBOLS  = mpd_pkg::MAX_SYMBOLS,
    parameter int COUNTER_BITS = mpd_pkg::COUNTER_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // tick channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_key_pressed,
    // configuration channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mpd_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [mpd_pkg::CFG_W-1:0]   cfg_data,
    // queue side
    output logic                             push,
    output mpd_pkg::burst_t                  push_data,
    input  wire logic                        queue_full
);

    localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
    localparam int CMP_W = (COUNTER_BITS > mpd_pkg::CFG_W) ? COUNTER_BITS : mpd_pkg::CFG_W;

    // Configuration
    logic [mpd_pkg::CFG_W-1:0] dah_threshold_reg;
    logic [mpd_pkg::CFG_W-1:0] letter_gap_reg;
    logic [mpd_pkg::CFG_W-1:0] word_gap_reg;
    logic [mpd_pkg::CFG_W-1:0] receive_timeout_reg;

    // Timing state
    logic [COUNTER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                    prev_level_reg, prev_level_next;
    logic [MAX_SYMBOLS-1:0]  pattern_reg, pattern_next;
    logic [LEN_W-1:0]        length_reg, length_next;
    logic                    overflow_reg, overflow_next;
    logic                    pending_reg, pending_next;

    logic                    accept;
    logic                    changed;
    logic [COUNTER_BITS-1:0] elapsed_inc;
    logic [COUNTER_BITS-1:0] duration;
    logic [CMP_W-1:0]        dur_cmp;
    logic                    is_dit;
    logic                    timeout;
    logic                    is_pause;
    logic                    letter_ev;
    logic                    word_ev;
    logic [MAX_SYMBOLS+mpd_pkg::BITS_W-1:0] pattern_ext;
    logic [LEN_W+mpd_pkg::COUNT_W-1:0]      length_ext;

    assign s_ready   = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Interval timing
    assign changed     = (s_key_pressed != prev_level_reg);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign duration    = changed ? elapsed_reg : elapsed_inc;
    assign dur_cmp     = CMP_W'(duration);
    assign is_dit      = (dur_cmp < CMP_W'(dah_threshold_reg));
    assign timeout     = !changed && (dur_cmp > CMP_W'(receive_timeout_reg))
                         && (pending_reg || (length_reg != '0));
    assign is_pause    = (changed && !prev_level_reg) || timeout;
    assign letter_ev   = is_pause && (dur_cmp >= CMP_W'(letter_gap_reg))
                         && (length_reg != '0);
    assign word_ev     = is_pause && (dur_cmp >= CMP_W'(word_gap_reg))
                         && (pending_reg || letter_ev);

    // Descriptor, fields cut to their port widths
    assign pattern_ext = {{mpd_pkg::BITS_W{1'b0}}, pattern_reg};
    assign length_ext  = {{mpd_pkg::COUNT_W{1'b0}}, length_reg};

    always_comb begin
        push_data.has_letter = letter_ev;
        push_data.has_word   = word_ev;
        push_data.has_end    = timeout;
        push_data.count      = length_ext[mpd_pkg::COUNT_W-1:0];
        push_data.bits       = pattern_ext[mpd_pkg::BITS_W-1:0];
        push_data.too_long   = overflow_reg;
    end

    assign push = accept && (letter_ev || word_ev || timeout);

    // Next timing state
    always_comb begin
        elapsed_next    = elapsed_reg;
        prev_level_next = prev_level_reg;
        pattern_next    = pattern_reg;
        length_next     = length_reg;
        overflow_next   = overflow_reg;
        pending_next    = pending_reg;
        if (accept) begin
            prev_level_next = s_key_pressed;
            if (timeout) begin
                elapsed_next = '0;
            end else if (changed) begin
                elapsed_next = COUNTER_BITS'(1);
            end else begin
                elapsed_next = elapsed_inc;
            end
            // finished press: append a symbol or mark overflow
            if (changed && prev_level_reg) begin
                if (length_reg >= LEN_W'(MAX_SYMBOLS)) begin
                    overflow_next = 1'b1;
                end else begin
                    pattern_next = {pattern_reg[MAX_SYMBOLS-2:0], is_dit};
                    length_next  = length_reg + 1'b1;
                end
            end
            // letter emitted: clear collected symbols
            if (letter_ev) begin
                pattern_next  = '0;
                length_next   = '0;
                overflow_next = 1'b0;
                pending_next  = 1'b1;
            end
            if (timeout) begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg    <= '0;
            prev_level_reg <= 1'b0;
            pattern_reg    <= '0;
            length_reg     <= '0;
            overflow_reg   <= 1'b0;
            pending_reg    <= 1'b0;
        end else begin
            elapsed_reg    <= elapsed_next;
            prev_level_reg <= prev_level_next;
            pattern_reg    <= pattern_next;
            length_reg     <= length_next;
            overflow_reg   <= overflow_next;
            pending_reg    <= pending_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dah_threshold_reg   <= mpd_pkg::DAH_THRESHOLD_RST;
            letter_gap_reg      <= mpd_pkg::LETTER_GAP_RST;
            word_gap_reg        <= mpd_pkg::WORD_GAP_RST;
            receive_timeout_reg <= mpd_pkg::RECEIVE_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mpd_pkg::REG_DAH_THRESHOLD:   dah_threshold_reg   <= cfg_data;
                mpd_pkg::REG_LETTER_GAP:      letter_gap_reg      <= cfg_data;
                mpd_pkg::REG_WORD_GAP:        word_gap_reg        <= cfg_data;
                mpd_pkg::REG_RECEIVE_TIMEOUT: receive_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule : mpd_front

`default_nettype wire

FILE: src/mpd_back.sv
// ============================================================================
// mpd_back: result sequencer
// Takes one descriptor at a time from the queue and hands its results out
// as beats on the result channel, in order letter, word gap, end of message,
// with last on the final beat of the tick.
// ============================================================================
`default_nettype none

module mpd_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // queue side
    input  wire logic                        queue_not_empty,
    input  wire mpd_pkg::burst_t             queue_data,
    output logic                             pop,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mpd_pkg::KIND_W-1:0]       m_event_kind,
    output logic [mpd_pkg::COUNT_W-1:0]      m_symbol_count,
    output logic [mpd_pkg::BITS_W-1:0]       m_symbol_bits,
    output logic                             m_pattern_too_long,
    output logic                             m_last
);

    logic                       busy_reg, busy_next;
    logic                       letter_reg, letter_next;
    logic                       word_reg, word_next;
    logic                       end_reg, end_next;
    logic [mpd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [mpd_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic                       long_reg, long_next;

    logic                 fire;
    logic                 final_beat;
    mpd_pkg::event_kind_t kind;

    // Current beat: first remaining result of the descriptor
    always_comb begin
        if (letter_reg) begin
            kind       = mpd_pkg::EV_LETTER;
            final_beat = !(word_reg || end_reg);
        end else if (word_reg) begin
            kind       = mpd_pkg::EV_WORD_GAP;
            final_beat = !end_reg;
        end else begin
            kind       = mpd_pkg::EV_END_MSG;
            final_beat = 1'b1;
        end
    end

    assign m_valid            = busy_reg;
    assign m_event_kind       = kind;
    assign m_symbol_count     = letter_reg ? count_reg : '0;
    assign m_symbol_bits      = letter_reg ? bits_reg : '0;
    assign m_pattern_too_long = letter_reg && long_reg;
    assign m_last             = final_beat;

    assign fire = busy_reg && m_ready;
    assign pop  = queue_not_empty && (!busy_reg || (fire && final_beat));

    // Beat sequencing
    always_comb begin
        busy_next   = busy_reg;
        letter_next = letter_reg;
        word_next   = word_reg;
        end_next    = end_reg;
        count_next  = count_reg;
        bits_next   = bits_reg;
        long_next   = long_reg;
        if (pop) begin
            busy_next   = 1'b1;
            letter_next = queue_data.has_letter;
            word_next   = queue_data.has_word;
            end_next    = queue_data.has_end;
            count_next  = queue_data.count;
            bits_next   = queue_data.bits;
            long_next   = queue_data.too_long;
        end else if (fire) begin
            if (final_beat) begin
                busy_next = 1'b0;
            end else if (letter_reg) begin
                letter_next = 1'b0;
            end else begin
                word_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            letter_reg <= 1'b0;
            word_reg   <= 1'b0;
            end_reg    <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            letter_reg <= letter_next;
            word_reg   <= word_next;
            end_reg    <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        bits_reg  <= bits_next;
        long_reg  <= long_next;
    end

endmodule : mpd_back

`default_nettype wire

FILE: src/morse_paddle_decoder_core.sv
// ============================================================================
// morse_paddle_decoder_core: Morse key timing decoder, top level
// Path: results of an accepted tick are registered into the queue and then
// into the sequencer before they appear on m_. Throughput: one tick per
// cycle while the queue is not full; each result takes one beat, and the
// queue of QUEUE_DEPTH descriptors between classifier and sequencer absorbs
// ticks whose results take more than one beat. Reset: synchronous, active
// low; registers return to defaults, timing state clears, the queue empties.
// ============================================================================
`default_nettype none

module morse_paddle_decoder_core #(
    parameter int MAX_SYMBOLS  = mpd_pkg::MAX_SYMBOLS,
    parameter int COUNTER_BITS = mpd_pkg::COUNTER_BITS,
    parameter int QUEUE_DEPTH  = mpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // tick channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_key_pressed,
    // configuration channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mpd_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [mpd_pkg::CFG_W-1:0]   cfg_data,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mpd_pkg::KIND_W-1:0]       m_event_kind,
    output logic [mpd_pkg::COUNT_W-1:0]      m_symbol_count,
    output logic [mpd_pkg::BITS_W-1:0]       m_symbol_bits,
    output logic                             m_pattern_too_long,
    output logic                             m_last
);

    localparam int BURST_W = $bits(mpd_pkg::burst_t);

    logic            push;
    mpd_pkg::burst_t push_data;
    logic            queue_full;
    logic            pop;
    logic            queue_not_empty;
    mpd_pkg::burst_t pop_data;

    // Classifier
    mpd_front #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_pressed (s_key_pressed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .push_data     (push_data),
        .queue_full    (queue_full)
    );

    // Descriptor queue
    mpd_fifo #(
        .WIDTH (BURST_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    // Result sequencer
    mpd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .queue_not_empty    (queue_not_empty),
        .queue_data         (pop_data),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_symbol_count     (m_symbol_count),
        .m_symbol_bits      (m_symbol_bits),
        .m_pattern_too_long (m_pattern_too_long),
        .m_last             (m_last)
    );

endmodule : morse_paddle_decoder_core

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Feeds millisecond key ticks through morse_paddle_decoder_core, decodes the
// same ticks in a behavioral model and compares every result beat in order.
// Covers the reset register values, zero registers, symbol overflow,
// timeouts with the key held or released, long result-side stalls and
// randomized keying under random idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_TICKS  = 180;

    // One decoded event as it should appear on the result port
    typedef struct packed {
        event_kind_t        kind;
        logic [COUNT_W-1:0] count;
        logic [BITS_W-1:0]  sym_bits;
        logic               too_long;
        logic               last;
    } morse_event_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_key_pressed  = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [INDEX_W-1:0]   cfg_index      = REG_DAH_THRESHOLD;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [KIND_W-1:0]    m_event_kind;
    logic [COUNT_W-1:0]   m_symbol_count;
    logic [BITS_W-1:0]    m_symbol_bits;
    logic                 m_pattern_too_long;
    logic                 m_last;

    // Decoder model: registers and timing state
    logic [CFG_W-1:0]        dah_thr;
    logic [CFG_W-1:0]        letter_gap_ms;
    logic [CFG_W-1:0]        word_gap_ms;
    logic [CFG_W-1:0]        rx_timeout;
    logic [COUNTER_BITS-1:0] elapsed;
    logic                    prev_key;
    logic [BITS_W-1:0]       pat_bits;
    logic [COUNT_W-1:0]      pat_len;
    logic                    pat_ovf;
    logic                    letters_open;

    morse_event_t tick_events[$];
    morse_event_t decoded_events[$];

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   tx_gap_max  = 12;
    int   rx_stall_max = 12;
    logic rx_hold_on  = 1'b0;
    event hold_go;

    morse_paddle_decoder_core i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_key_pressed      (s_key_pressed),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_symbol_count     (m_symbol_count),
        .m_symbol_bits      (m_symbol_bits),
        .m_pattern_too_long (m_pattern_too_long),
        .m_last             (m_last)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("morse_paddle_decoder_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic void reset_decoder();
        dah_thr       = DAH_THRESHOLD_RST;
        letter_gap_ms = LETTER_GAP_RST;
        word_gap_ms   = WORD_GAP_RST;
        rx_timeout    = RECEIVE_TIMEOUT_RST;
        elapsed       = '0;
        prev_key      = 1'b0;
        pat_bits      = '0;
        pat_len       = '0;
        pat_ovf       = 1'b0;
        letters_open  = 1'b0;
    endfunction

    function automatic void store_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_DAH_THRESHOLD:   dah_thr       = value;
            REG_LETTER_GAP:      letter_gap_ms = value;
            REG_WORD_GAP:        word_gap_ms   = value;
            REG_RECEIVE_TIMEOUT: rx_timeout    = value;
            default: ;
        endcase
    endfunction

    // Time one finished press or pause
    function automatic void close_interval(logic was_pressed, logic [COUNTER_BITS-1:0] dur);
        if (was_pressed) begin
            if (pat_len >= MAX_SYMBOLS) begin
                pat_ovf = 1'b1;
            end else begin
                pat_bits = {pat_bits[BITS_W-2:0], (dur < dah_thr)};
                pat_len  = pat_len + 1'b1;
            end
        end else begin
            if (dur >= letter_gap_ms && pat_len != 0) begin
                tick_events.push_back('{kind: EV_LETTER, count: pat_len, sym_bits: pat_bits,
                                        too_long: pat_ovf, last: 1'b0});
                letters_open = 1'b1;
                pat_bits     = '0;
                pat_len      = '0;
                pat_ovf      = 1'b0;
            end
            if (dur >= word_gap_ms && letters_open)
                tick_events.push_back('{kind: EV_WORD_GAP, count: '0, sym_bits: '0,
                                        too_long: 1'b0, last: 1'b0});
        end
    endfunction

    // One accepted tick: update timing state, queue the events it causes
    function automatic void decode_tick(logic key);
        logic changed;
        tick_events.delete();
        changed = (key != prev_key);
        if (changed) begin
            close_interval(prev_key, elapsed);
            elapsed = '0;
        end
        prev_key = key;
        if (elapsed != '1)
            elapsed = elapsed + 1'b1;
        // timeout flush, also while the key is held
        if (!changed && elapsed > rx_timeout && (letters_open || pat_len != 0)) begin
            close_interval(1'b0, elapsed);
            tick_events.push_back('{kind: EV_END_MSG, count: '0, sym_bits: '0,
                                    too_long: 1'b0, last: 1'b0});
            letters_open = 1'b0;
            elapsed      = '0;
        end
        if (tick_events.size() != 0)
            tick_events[tick_events.size()-1].last = 1'b1;
        foreach (tick_events[i])
            decoded_events.push_back(tick_events[i]);
    endfunction

    function automatic void check_event();
        morse_event_t want;
        if (decoded_events.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("unexpected beat: kind %0d count %0d bits %02h long %0b last %0b",
                         m_event_kind, m_symbol_count, m_symbol_bits, m_pattern_too_long,
                         m_last);
            mismatches++;
        end else begin
            want = decoded_events.pop_front();
            if (m_event_kind !== want.kind || m_symbol_count !== want.count ||
                m_symbol_bits !== want.sym_bits || m_pattern_too_long !== want.too_long ||
                m_last !== want.last) begin
                if (mismatches < MAX_REPORTS) begin
                    $write("beat mismatch: expected kind %0d count %0d bits %02h long %0b",
                           want.kind, want.count, want.sym_bits, want.too_long);
                    $write(" last %0b, got kind %0d count %0d bits %02h",
                           want.last, m_event_kind, m_symbol_count, m_symbol_bits);
                    $display(" long %0b last %0b", m_pattern_too_long, m_last);
                end
                mismatches++;
            end
        end
    endfunction

    // Sample all three channels at the edge where their beats complete
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                store_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                decode_tick(s_key_pressed);
            if (m_valid && m_ready)
                check_event();
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0 || rx_hold_on) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (rx_hold_on) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        forever begin
            @(hold_go);
            rx_hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // valid stays up across back-to-back beats; it only drops for a gap
    task automatic send_tick(input logic key);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_key_pressed <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_key(input logic key, input int ticks);
        repeat (ticks) send_tick(key);
    endtask

    // Drop valid, wait for every owed beat, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_W-1:0] dah, input logic [CFG_W-1:0] letter,
                             input logic [CFG_W-1:0] word, input logic [CFG_W-1:0] timeout);
        write_reg(REG_DAH_THRESHOLD, dah);
        write_reg(REG_LETTER_GAP, letter);
        write_reg(REG_WORD_GAP, word);
        write_reg(REG_RECEIVE_TIMEOUT, timeout);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small register values so that gaps are reachable in few ticks
    function automatic logic [CFG_W-1:0] random_reg_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            default: return CFG_W'($urandom_range(2, 10));
        endcase
    endfunction

    // A duration just below, at or just above a register value capped at 20
    function automatic int near_value(logic [CFG_W-1:0] target);
        int t;
        int r;
        int v;
        t = (target > 19) ? 20 : int'(target);
        r = $urandom_range(0, 2);
        v = t + r - 1;
        return (v < 1) ? 1 : v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Register reset values: short presses collect dits and short pauses
    // stay inside the default gaps; the letter then leaves by a timeout
    // under small gaps (three beats)
    task automatic test_reset_defaults();
        hold_key(1'b1, 3);
        hold_key(1'b0, 2);
        hold_key(1'b1, 4);
        hold_key(1'b0, 2);
        wait_idle();
        configure(DAH_THRESHOLD_RST, 16'd3, 16'd5, 16'd8);
        hold_key(1'b0, 9);
        wait_idle();
    endtask

    // Nine symbols: the ninth is dropped and the letter is flagged too long
    task automatic test_symbol_overflow();
        int press_len[9] = '{1, 2, 1, 1, 2, 2, 1, 2, 1};
        tx_gap_max = 12;
        configure(16'd2, 16'd3, 16'd5, 16'd8);
        foreach (press_len[i]) begin
            hold_key(1'b1, press_len[i]);
            hold_key(1'b0, 1);
        end
        hold_key(1'b0, 9);
        wait_idle();
    endtask

    // All registers zero: every press a dah, every pause ends the letter
    task automatic test_zero_registers();
        configure('0, '0, '0, '0);
        hold_key(1'b1, 2);
        hold_key(1'b0, 1);
        hold_key(1'b1, 1);
        hold_key(1'b0, 3);
        wait_idle();
    endtask

    task automatic test_timeouts();
        // timeout before the letter gap: symbols stay and the timeout repeats
        configure(16'd3, 16'd6, 16'd2, 16'd2);
        hold_key(1'b1, 1);
        hold_key(1'b0, 7);
        hold_key(1'b1, 5);
        hold_key(1'b0, 8);
        wait_idle();
        // timeout while the key is held, with a letter already sent
        configure(16'd20, 16'd2, 16'd3, 16'd4);
        hold_key(1'b1, 1);
        hold_key(1'b0, 2);
        hold_key(1'b1, 6);
        hold_key(1'b0, 1);
        wait_idle();
        // repeated word gaps until the message ends
        configure(16'd3, 16'd2, 16'd3, 16'd12);
        repeat (3) begin
            hold_key(1'b1, 1);
            hold_key(1'b0, 4);
        end
        hold_key(1'b0, 12);
        wait_idle();
    endtask

    // Result port held off while ticks keep coming: the queue fills up
    task automatic test_result_backpressure();
        configure(16'd1, 16'd1, 16'd1, 16'd2);
        tx_gap_max = 0;
        ->hold_go;
        repeat (30) begin
            hold_key(1'b1, 1);
            hold_key(1'b0, 1);
        end
        hold_key(1'b0, 4);
        wait_idle();
    endtask

    task automatic test_random_keying();
        int sent;
        int phase_end;
        int press_len;
        int pause_len;
        int cap;
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            configure(random_reg_value(), random_reg_value(), random_reg_value(),
                      random_reg_value());
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            phase_end    = sent + 40;
            while (sent < phase_end) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise
                    send_tick(1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    cap = (dah_thr > 11) ? 12 : int'(dah_thr) + 1;
                    if ($urandom_range(0, 7) == 0)
                        press_len = near_value(rx_timeout);
                    else
                        press_len = $urandom_range(1, cap);
                    case ($urandom_range(0, 4))
                        0:       pause_len = $urandom_range(1, 3);
                        1:       pause_len = near_value(letter_gap_ms);
                        2:       pause_len = near_value(word_gap_ms);
                        3:       pause_len = near_value(rx_timeout);
                        default: pause_len = $urandom_range(1, 20);
                    endcase
                    hold_key(1'b1, press_len);
                    hold_key(1'b0, pause_len);
                    sent += press_len + pause_len;
                end
            end
            wait_idle();
        end
        rx_stall_max = 12;
    endtask

    initial begin
        reset_decoder();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_symbol_overflow();
        test_zero_registers();
        test_timeouts();
        test_result_backpressure();
        test_random_keying();
        wait_idle();

        if (mismatches == 0 && decoded_events.size() == 0)
            $display("morse_paddle_decoder_core: match");
        else
            $display("morse_paddle_decoder_core: mismatch");
        $finish;
    end

endmodule

FILE: morse_paddle_decoder_core.f
src/mpd_pkg.sv
src/mpd_fifo.sv
src/mpd_front.sv
src/mpd_back.sv
src/morse_paddle_decoder_core.sv
sim/testbench.sv
